/* hdl/sti_pkg.sv */
package sti_pkg;

  // coordinate and datapath widths
  localparam int COORD_W = 24;
  localparam int N_W = COORD_W + 1;       // difference of two coordinates
  localparam int K_W = COORD_W + 2;       // low chunk of a wide operand
  localparam int X_W = K_W + 1;           // multiplier x operand
  localparam int P_W = X_W + N_W;         // product
  localparam int W_W = 2 * COORD_W + 3;   // cross product component
  localparam int A_W = 3 * COORD_W + 6;   // accumulator

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    RSN_HIT      = 3'd0,
    RSN_BOX      = 3'd1,
    RSN_PARALLEL = 3'd2,
    RSN_BEYOND   = 3'd3,
    RSN_OUTSIDE  = 3'd4
  } reason_t;

  localparam logic [1:0] SLOT_NONE = 2'd3;

  typedef struct packed {
    logic                       command;
    logic [1:0]                 slot;
    logic signed [COORD_W-1:0]  a_x;
    logic signed [COORD_W-1:0]  a_y;
    logic signed [COORD_W-1:0]  a_z;
    logic signed [COORD_W-1:0]  b_x;
    logic signed [COORD_W-1:0]  b_y;
    logic signed [COORD_W-1:0]  b_z;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] reason;
  } out_t;

  // top level control
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_RUN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_NORM,
    PH_DEN,
    PH_NUM,
    PH_CROSS,
    PH_DOT
  } phase_t;

  // difference vectors
  typedef enum logic [2:0] {
    VS_E1,   // v1 - v0
    VS_E2,   // v2 - v0
    VS_AMB,  // a - b
    VS_AMV,  // a - v0
    VS_D,    // b - a
    VS_P0,   // v0 - a
    VS_P1,   // v1 - a
    VS_P2    // v2 - a
  } vsel_t;

  typedef enum logic [2:0] {
    DST_N,
    DST_C,
    DST_DEN,
    DST_NUM,
    DST_TRI
  } dest_t;

  typedef struct packed {
    logic       valid;
    logic       xwide;   // x comes from a stored wide vector
    logic       from_c;  // wide source: 0 normal, 1 edge cross
    logic       hi;      // high chunk of a wide x
    vsel_t      xsel;
    logic [1:0] xax;
    vsel_t      ysel;
    logic [1:0] yax;
    logic       neg;
    logic       first;
    logic       last;
    dest_t      dest;
    logic [1:0] comp;
  } uop_t;

  typedef struct packed {
    logic       valid;
    logic       shift;
    logic       neg;
    logic       first;
    logic       last;
    dest_t      dest;
    logic [1:0] comp;
  } mac_ctl_t;

  typedef struct packed {
    logic                   valid;
    dest_t                  dest;
    logic [1:0]             comp;
    logic signed [A_W-1:0]  sum;
  } mac_res_t;

  function automatic logic signed [N_W-1:0] vdiff(
    input vsel_t                     sel,
    input logic signed [COORD_W-1:0] v0,
    input logic signed [COORD_W-1:0] v1,
    input logic signed [COORD_W-1:0] v2,
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W-1:0] m;
    logic signed [COORD_W-1:0] s;
    m = v1;
    s = v0;
    case (sel)
      VS_E1: begin m = v1; s = v0; end
      VS_E2: begin m = v2; s = v0; end
      VS_AMB: begin m = a; s = b; end
      VS_AMV: begin m = a; s = v0; end
      VS_D: begin m = b; s = a; end
      VS_P0: begin m = v0; s = a; end
      VS_P1: begin m = v1; s = a; end
      VS_P2: begin m = v2; s = a; end
      default: begin m = v1; s = v0; end
    endcase
    return $signed({m[COORD_W-1], m}) - $signed({s[COORD_W-1], s});
  endfunction

endpackage

/* hdl/segment_triangle_intersect.sv */
// segment against triangle test with exact integer arithmetic. a load
// transaction (command 0) writes one vertex into slot 0 to 2 and gives no
// result; slot 3 is ignored. a test transaction (command 1) gives one result:
// hit and a reason (0 hit, 1 box reject, 2 parallel, 3 beyond segment,
// 4 outside triangle). a load leaves in_ready high. a test that the bounding box
// rejects goes from ST_BOX to ST_FINISH and the output register; any other test
// runs ST_RUN, ST_DRAIN and ST_DECIDE on one shared 27x25 multiplier feeding a
// 78-bit accumulator that works through the 54 products (normal, two plane dot
// products and three triple products, wide operands in two chunks) one a cycle.
// in_ready is low while a test runs; a finished result waits in the output
// register while the next transaction is taken.
module segment_triangle_intersect
  import sti_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t state_r, state_nxt;

  // stored triangle, [vertex][axis]
  logic signed [COORD_W-1:0] vtx_r [3][3];
  // segment endpoints of the running test
  logic signed [COORD_W-1:0] a_r [3];
  logic signed [COORD_W-1:0] b_r [3];

  // intermediate results written back by the accumulator
  logic signed [W_W-1:0] n_r [3];
  logic signed [W_W-1:0] c_r [3];
  logic signed [A_W-1:0] den_r;
  logic signed [A_W-1:0] num_r;
  logic [2:0] tri_neg_r;
  logic [2:0] tri_pos_r;

  logic [1:0] drain_r, drain_nxt;
  reason_t    rsn_r, rsn_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_r;

  logic     in_acc;
  logic     box_rej;
  logic     seq_start;
  logic     seq_done;
  uop_t     uop;
  mac_ctl_t ctl_r;
  mac_res_t res;

  logic signed [X_W-1:0] op_x_r, op_x_nxt;
  logic signed [N_W-1:0] op_y_r, op_y_nxt;
  logic signed [W_W-1:0] wsrc;
  logic signed [N_W-1:0] xn;

  logic signed [A_W:0] nd_diff;
  logic den_zero, den_neg, num_neg, num_pos, diff_neg, diff_pos;
  logic beyond, outside;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // vertex store and endpoint capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          vtx_r[k][j] <= '0;
        end
      end
    end else if (in_acc && in_data.command == CMD_LOAD && in_data.slot != SLOT_NONE) begin
      vtx_r[in_data.slot][0] <= in_data.a_x;
      vtx_r[in_data.slot][1] <= in_data.a_y;
      vtx_r[in_data.slot][2] <= in_data.a_z;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r[0] <= in_data.a_x;
      a_r[1] <= in_data.a_y;
      a_r[2] <= in_data.a_z;
      b_r[0] <= in_data.b_x;
      b_r[1] <= in_data.b_y;
      b_r[2] <= in_data.b_z;
    end
  end

  // bounding box reject: both endpoints strictly below min or above max
  always_comb begin
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    box_rej = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      lo = vtx_r[0][ax];
      hi = vtx_r[0][ax];
      for (int k = 1; k < 3; k++) begin
        if (vtx_r[k][ax] < lo) lo = vtx_r[k][ax];
        if (vtx_r[k][ax] > hi) hi = vtx_r[k][ax];
      end
      if ((a_r[ax] < lo && b_r[ax] < lo) || (a_r[ax] > hi && b_r[ax] > hi)) begin
        box_rej = 1'b1;
      end
    end
  end

  sti_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seq_start),
    .uop   (uop),
    .done  (seq_done)
  );

  // operand fetch: difference vectors or a chunk of a stored wide vector
  always_comb begin
    wsrc = uop.from_c ? c_r[uop.xax] : n_r[uop.xax];
    xn = vdiff(uop.xsel, vtx_r[0][uop.xax], vtx_r[1][uop.xax], vtx_r[2][uop.xax],
               a_r[uop.xax], b_r[uop.xax]);
    if (!uop.xwide) begin
      op_x_nxt = {{(X_W-N_W){xn[N_W-1]}}, xn};
    end else if (uop.hi) begin
      op_x_nxt = {{(X_W-(W_W-K_W)){wsrc[W_W-1]}}, wsrc[W_W-1:K_W]};
    end else begin
      op_x_nxt = {1'b0, wsrc[K_W-1:0]};
    end
    op_y_nxt = vdiff(uop.ysel, vtx_r[0][uop.yax], vtx_r[1][uop.yax], vtx_r[2][uop.yax],
                     a_r[uop.yax], b_r[uop.yax]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid <= uop.valid;
      ctl_r.shift <= uop.xwide && uop.hi;
      ctl_r.neg   <= uop.neg;
      ctl_r.first <= uop.first;
      ctl_r.last  <= uop.last;
      ctl_r.dest  <= uop.dest;
      ctl_r.comp  <= uop.comp;
    end
  end

  always_ff @(posedge clk) begin
    op_x_r <= op_x_nxt;
    op_y_r <= op_y_nxt;
  end

  sti_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_r),
    .op_x  (op_x_r),
    .op_y  (op_y_r),
    .res   (res)
  );

  // write back finished sums
  always_ff @(posedge clk) begin
    if (res.valid) begin
      case (res.dest)
        DST_N: n_r[res.comp] <= res.sum[W_W-1:0];
        DST_C: c_r[res.comp] <= res.sum[W_W-1:0];
        DST_DEN: den_r <= res.sum;
        DST_NUM: num_r <= res.sum;
        DST_TRI: begin
          tri_neg_r[res.comp] <= res.sum[A_W-1];
          tri_pos_r[res.comp] <= !res.sum[A_W-1] && (res.sum != '0);
        end
        default: ;
      endcase
    end
  end

  // final classification from den, num and the triple product signs
  always_comb begin
    nd_diff  = {num_r[A_W-1], num_r} - {den_r[A_W-1], den_r};
    den_zero = (den_r == '0);
    den_neg  = den_r[A_W-1];
    num_neg  = num_r[A_W-1];
    num_pos  = !num_r[A_W-1] && (num_r != '0);
    diff_neg = nd_diff[A_W];
    diff_pos = !nd_diff[A_W] && (nd_diff != '0);
    // with a negative den the comparisons flip instead of negating both
    beyond  = den_neg ? (num_pos || diff_neg) : (num_neg || diff_pos);
    outside = (tri_pos_r[0] && tri_neg_r[1]) || (tri_neg_r[0] && tri_pos_r[1]) ||
              (tri_pos_r[0] && tri_neg_r[2]) || (tri_neg_r[0] && tri_pos_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drain_r     <= '0;
      rsn_r       <= RSN_HIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drain_r     <= drain_nxt;
      rsn_r       <= rsn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && (!out_valid_r || out_ready)) begin
      out_r.hit    <= (rsn_r == RSN_HIT);
      out_r.reason <= rsn_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    drain_nxt     = drain_r;
    rsn_nxt       = rsn_r;
    out_valid_nxt = out_valid_r && !out_ready;
    seq_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.command == CMD_TEST) begin
          state_nxt = ST_BOX;
        end
      end
      ST_BOX: begin
        if (box_rej) begin
          rsn_nxt   = RSN_BOX;
          state_nxt = ST_FINISH;
        end else begin
          seq_start = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (seq_done) begin
          drain_nxt = 2'd2;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last product still in the multiplier and accumulator
        drain_nxt = drain_r - 2'd1;
        if (drain_r == 2'd1) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (den_zero) begin
          rsn_nxt = RSN_PARALLEL;
        end else if (beyond) begin
          rsn_nxt = RSN_BEYOND;
        end else if (outside) begin
          rsn_nxt = RSN_OUTSIDE;
        end else begin
          rsn_nxt = RSN_HIT;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* hdl/sti_seq.sv */
module sti_seq
  import sti_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output uop_t uop,
  output logic done
);

  logic       run_r, run_nxt;
  phase_t     phase_r, phase_nxt;
  logic [2:0] step_r, step_nxt;
  logic [1:0] tri_r, tri_nxt;

  logic [1:0] comp;
  logic       odd;
  logic [1:0] ax1, ax2;
  vsel_t      psel, qsel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      phase_r <= PH_NORM;
      step_r  <= '0;
      tri_r   <= '0;
    end else begin
      run_r   <= run_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      tri_r   <= tri_nxt;
    end
  end

  always_comb begin
    comp = step_r[2:1];
    odd  = step_r[0];
    ax1  = (comp == 2'd2) ? 2'd0 : comp + 2'd1;
    ax2  = (comp == 2'd0) ? 2'd2 : comp - 2'd1;
    case (tri_r)
      2'd0: begin psel = VS_P1; qsel = VS_P0; end
      2'd1: begin psel = VS_P0; qsel = VS_P2; end
      default: begin psel = VS_P2; qsel = VS_P1; end
    endcase

    uop = '0;
    uop.valid = run_r;
    uop.comp  = comp;
    case (phase_r)
      PH_NORM, PH_CROSS: begin
        // r[c] = p[c+1] q[c+2] - p[c+2] q[c+1]
        uop.xsel  = (phase_r == PH_NORM) ? VS_E1 : psel;
        uop.ysel  = (phase_r == PH_NORM) ? VS_E2 : qsel;
        uop.xax   = odd ? ax2 : ax1;
        uop.yax   = odd ? ax1 : ax2;
        uop.neg   = odd;
        uop.first = !odd;
        uop.last  = odd;
        uop.dest  = (phase_r == PH_NORM) ? DST_N : DST_C;
      end
      PH_DEN, PH_NUM, PH_DOT: begin
        uop.xwide  = 1'b1;
        uop.from_c = (phase_r == PH_DOT);
        uop.hi     = odd;
        uop.xax    = comp;
        uop.yax    = comp;
        uop.first  = (step_r == 3'd0);
        uop.last   = (step_r == 3'd5);
        case (phase_r)
          PH_DEN: begin uop.ysel = VS_AMB; uop.dest = DST_DEN; end
          PH_NUM: begin uop.ysel = VS_AMV; uop.dest = DST_NUM; end
          default: begin
            uop.ysel = VS_D;
            uop.dest = DST_TRI;
            uop.comp = tri_r;
          end
        endcase
      end
      default: uop.valid = 1'b0;
    endcase

    run_nxt   = run_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    tri_nxt   = tri_r;
    done      = 1'b0;
    if (!run_r) begin
      if (start) begin
        run_nxt   = 1'b1;
        phase_nxt = PH_NORM;
        step_nxt  = '0;
        tri_nxt   = '0;
      end
    end else if (step_r != 3'd5) begin
      step_nxt = step_r + 3'd1;
    end else begin
      step_nxt = '0;
      case (phase_r)
        PH_NORM: phase_nxt = PH_DEN;
        PH_DEN: phase_nxt = PH_NUM;
        PH_NUM: phase_nxt = PH_CROSS;
        PH_CROSS: phase_nxt = PH_DOT;
        PH_DOT: begin
          if (tri_r == 2'd2) begin
            run_nxt = 1'b0;
            done    = 1'b1;
          end else begin
            tri_nxt   = tri_r + 2'd1;
            phase_nxt = PH_CROSS;
          end
        end
        default: run_nxt = 1'b0;
      endcase
    end
  end

endmodule

/* hdl/sti_mac.sv */
module sti_mac
  import sti_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  mac_ctl_t              ctl,
  input  logic signed [X_W-1:0] op_x,
  input  logic signed [N_W-1:0] op_y,
  output mac_res_t              res
);

  mac_ctl_t              ctl_r;
  logic signed [P_W-1:0] prod_r;
  logic signed [A_W-1:0] acc_r;
  logic signed [A_W-1:0] term;
  logic signed [A_W-1:0] base;
  logic signed [A_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_x * op_y;
    if (ctl_r.valid) begin
      acc_r <= sum;
    end
  end

  always_comb begin
    term = {{(A_W-P_W){prod_r[P_W-1]}}, prod_r};
    if (ctl_r.shift) begin
      term = term <<< K_W;
    end
    base = ctl_r.first ? '0 : acc_r;
    sum  = ctl_r.neg ? base - term : base + term;
    res.valid = ctl_r.valid && ctl_r.last;
    res.dest  = ctl_r.dest;
    res.comp  = ctl_r.comp;
    res.sum   = sum;
  end

endmodule

/* hdl/sti_checker.sv */
module sti_checker
  import sti_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hit == (out_data.reason == RSN_HIT)))
    else $error("hit flag disagrees with reason");

  a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.reason <= RSN_OUTSIDE))
    else $error("reason out of range");

  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_TEST |=> !in_ready)
    else $error("ready during a test");

  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_LOAD |=> in_ready)
    else $error("load stalled the input");

endmodule

bind segment_triangle_intersect sti_checker u_sti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
